>>> rtl/lrs_pkg.sv
package lrs_pkg;

    localparam int MAX_COLUMNS = 64;
    localparam int MIN_COLUMNS = 3;
    localparam int LANE_WIDTH  = 8;
    localparam int NUM_LANES   = MAX_COLUMNS / LANE_WIDTH;
    localparam int COL_W       = 7;
    localparam int COUNT_W     = 4;

    localparam logic [COUNT_W-1:0] BIRTH_COUNT = COUNT_W'(3);
    localparam logic [COUNT_W-1:0] SURVIVE_LOW = COUNT_W'(2);

    localparam logic [1:0] ROWS_FULL = 2'd2;

    typedef logic [MAX_COLUMNS-1:0] row_t;
    typedef logic [LANE_WIDTH+1:0] lane_win_t;
    typedef logic [NUM_LANES-1:0][LANE_WIDTH-1:0] lane_row_t;

endpackage

>>> rtl/lrs_lane.sv
module lrs_lane (
    input  lrs_pkg::lane_win_t                  up_win,
    input  lrs_pkg::lane_win_t                  mid_win,
    input  lrs_pkg::lane_win_t                  low_win,
    input  logic [lrs_pkg::LANE_WIDTH-1:0]      live_mask,
    output logic [lrs_pkg::LANE_WIDTH-1:0]      cells_next
);
    import lrs_pkg::*;

    always_comb begin
        logic [COUNT_W-1:0] n;
        logic               alive;
        for (int i = 0; i < LANE_WIDTH; i++) begin
            n = COUNT_W'(up_win[i]) + COUNT_W'(up_win[i+1]) + COUNT_W'(up_win[i+2])
              + COUNT_W'(mid_win[i]) + COUNT_W'(mid_win[i+2])
              + COUNT_W'(low_win[i]) + COUNT_W'(low_win[i+1]) + COUNT_W'(low_win[i+2]);
            alive = mid_win[i+1];
            cells_next[i] = live_mask[i] & ((n == BIRTH_COUNT) | (alive & (n == SURVIVE_LOW)));
        end
    end

endmodule

>>> rtl/lrs_merge.sv
module lrs_merge (
    input  lrs_pkg::lane_row_t lane_cells,
    output lrs_pkg::row_t      row_next,
    output logic               row_alive
);
    import lrs_pkg::*;

    always_comb begin
        for (int l = 0; l < NUM_LANES; l++) begin
            row_next[l*LANE_WIDTH +: LANE_WIDTH] = lane_cells[l];
        end
        row_alive = |lane_cells;
    end

endmodule

>>> rtl/life_rule_row_stencil.sv
// One generation of the B3/S23 life rule over a tile with a one-cell halo,
// streamed one row per item, top halo row first, bottom halo row marked by
// s_row_final. The first two rows of a tile only fill the row buffer; every
// later row yields one result, the next generation of the row above it, with
// halo and unused columns zero. The result for the bottom halo row has
// m_tile_done set and m_tile_alive reporting whether any interior cell of the
// new generation is alive. A final mark on one of the first two rows drops
// the tile. All columns are evaluated at once by eight-column lanes feeding
// one output register, so an item is accepted each cycle unless that
// register holds a result that is not taken. cfg_active_columns sets the
// tile width including both halo columns (clamped to 3..64) and should be
// written between tiles.
module life_rule_row_stencil (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [lrs_pkg::COL_W-1:0]  cfg_active_columns,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  lrs_pkg::row_t              s_row_cells,
    input  logic                       s_row_final,
    output logic                       m_valid,
    input  logic                       m_ready,
    output lrs_pkg::row_t              m_next_row_cells,
    output logic                       m_tile_done,
    output logic                       m_tile_alive
);
    import lrs_pkg::*;

    logic [COL_W-1:0] cols_reg;
    row_t             upper_reg, upper_next;
    row_t             middle_reg, middle_next;
    logic [1:0]       rows_seen_reg, rows_seen_next;
    logic             any_alive_reg, any_alive_next;
    logic             out_valid_reg, out_valid_next;
    row_t             out_cells_reg, out_cells_next;
    logic             out_done_reg, out_done_next;
    logic             out_alive_reg, out_alive_next;

    logic [COL_W-1:0] cols_eff;
    row_t             col_mask;
    row_t             live_mask;
    row_t             row_in;
    logic             s_fire;
    lane_row_t        lane_cells;
    row_t             row_next;
    logic             row_alive;

    logic [MAX_COLUMNS+1:0] up_pad, mid_pad, low_pad;

    assign cfg_ready = 1'b1;
    assign s_ready   = !out_valid_reg || m_ready;
    assign s_fire    = s_valid && s_ready;

    always_comb begin
        if (cols_reg < COL_W'(MIN_COLUMNS)) begin
            cols_eff = COL_W'(MIN_COLUMNS);
        end else if (cols_reg > COL_W'(MAX_COLUMNS)) begin
            cols_eff = COL_W'(MAX_COLUMNS);
        end else begin
            cols_eff = cols_reg;
        end
        for (int x = 0; x < MAX_COLUMNS; x++) begin
            col_mask[x]  = (COL_W'(x) < cols_eff);
            live_mask[x] = (x >= 1) && ((COL_W'(x) + COL_W'(2)) <= cols_eff);
        end
    end

    assign row_in  = s_row_cells & col_mask;
    assign up_pad  = {1'b0, upper_reg, 1'b0};
    assign mid_pad = {1'b0, middle_reg, 1'b0};
    assign low_pad = {1'b0, row_in, 1'b0};

    for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
        lrs_lane u_lane (
            .up_win     (up_pad[l*LANE_WIDTH +: LANE_WIDTH+2]),
            .mid_win    (mid_pad[l*LANE_WIDTH +: LANE_WIDTH+2]),
            .low_win    (low_pad[l*LANE_WIDTH +: LANE_WIDTH+2]),
            .live_mask  (live_mask[l*LANE_WIDTH +: LANE_WIDTH]),
            .cells_next (lane_cells[l])
        );
    end

    lrs_merge u_merge (
        .lane_cells (lane_cells),
        .row_next   (row_next),
        .row_alive  (row_alive)
    );

    always_comb begin
        upper_next     = upper_reg;
        middle_next    = middle_reg;
        rows_seen_next = rows_seen_reg;
        any_alive_next = any_alive_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_cells_next = out_cells_reg;
        out_done_next  = out_done_reg;
        out_alive_next = out_alive_reg;
        if (s_fire) begin
            if (rows_seen_reg != ROWS_FULL) begin
                if (s_row_final) begin
                    upper_next     = '0;
                    middle_next    = '0;
                    rows_seen_next = '0;
                    any_alive_next = 1'b0;
                end else begin
                    upper_next     = middle_reg;
                    middle_next    = row_in;
                    rows_seen_next = rows_seen_reg + 2'd1;
                end
            end else begin
                out_valid_next = 1'b1;
                out_cells_next = row_next;
                out_done_next  = s_row_final;
                out_alive_next = s_row_final && (any_alive_reg || row_alive);
                if (s_row_final) begin
                    upper_next     = '0;
                    middle_next    = '0;
                    rows_seen_next = '0;
                    any_alive_next = 1'b0;
                end else begin
                    upper_next     = middle_reg;
                    middle_next    = row_in;
                    any_alive_next = any_alive_reg || row_alive;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cols_reg      <= COL_W'(MAX_COLUMNS);
            upper_reg     <= '0;
            middle_reg    <= '0;
            rows_seen_reg <= '0;
            any_alive_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                cols_reg <= cfg_active_columns;
            end
            upper_reg     <= upper_next;
            middle_reg    <= middle_next;
            rows_seen_reg <= rows_seen_next;
            any_alive_reg <= any_alive_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_cells_reg <= out_cells_next;
        out_done_reg  <= out_done_next;
        out_alive_reg <= out_alive_next;
    end

    assign m_valid          = out_valid_reg;
    assign m_next_row_cells = out_cells_reg;
    assign m_tile_done      = out_done_reg;
    assign m_tile_alive     = out_alive_reg;

    a_rows_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        rows_seen_reg != 2'd3)
        else $error("row counter past saturation");

    a_final_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_row_final) |=> (rows_seen_reg == 2'd0 && !any_alive_reg))
        else $error("tile state not cleared after final row");

    a_no_early_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && rows_seen_reg != ROWS_FULL) |=> !out_valid_reg)
        else $error("result for a row that only fills the buffer");

    a_halo_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> !out_cells_reg[0])
        else $error("left halo column set in result");

    a_alive_with_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_alive_reg) |-> out_done_reg)
        else $error("tile alive flag without tile done");

endmodule
